// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AHFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define AHFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ahfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ahfr_pkg
// types, character codes and helper functions for the hex frame receiver
// ----------------------------------------------------------------------------
package ahfr_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_FRAME = 2'd1,
        PH_SKIP  = 2'd2,
        PH_CR    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       frame_good;
    } res_t;

    // ascii hex digit check, either case
    function automatic logic hex_is(input logic [7:0] c);
        hex_is = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // nibble value of a hex digit, don't care for other characters
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]})
            v = c - 8'h30;
        else if (c inside {[8'h61:8'h66]})
            v = c - 8'h57;
        else
            v = c - 8'h37;
        hex_val = v[3:0];
    endfunction

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++)
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        crc8_byte = v;
    endfunction

endpackage

// ===== hw/rtl/ahfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// ahfr_in_stage
// input register for received characters
// ----------------------------------------------------------------------------
module ahfr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_char
    input  logic       advance,
    output logic       char_valid,
    output logic [7:0] char_data
);
    import ahfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= s_tdata;
    end

    assign char_valid = valid_reg;
    assign char_data  = data_reg;

endmodule

// ===== hw/rtl/ahfr_frame_core.sv =====
// ----------------------------------------------------------------------------
// ahfr_frame_core
// line phase tracking, hex pair decode, crc-8 and one-byte hold-back
// ----------------------------------------------------------------------------
module ahfr_frame_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      char_data,
    output logic            res_valid,
    output ahfr_pkg::res_t  res,
    output ahfr_pkg::phase_t phase
);
    import ahfr_pkg::*;

    phase_t     phase_reg,   phase_next;
    logic       bad_reg,     bad_next;
    logic [3:0] high_reg,    high_next;
    logic       pend_reg,    pend_next;
    logic [7:0] held_reg,    held_next;
    logic       hvalid_reg,  hvalid_next;
    logic [7:0] crc_reg,     crc_next;
    logic [1:0] tally_reg,   tally_next;

    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] new_byte;

    assign is_hex   = hex_is(char_data);
    assign nib      = hex_val(char_data);
    assign new_byte = {high_reg, nib};

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        bad_next    = bad_reg;
        high_next   = high_reg;
        pend_next   = pend_reg;
        held_next   = held_reg;
        hvalid_next = hvalid_reg;
        crc_next    = crc_reg;
        tally_next  = tally_reg;
        if (fire)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (char_data == CHAR_COLON)
                    begin
                        phase_next  = PH_FRAME;
                        bad_next    = 1'b0;
                        high_next   = 4'd0;
                        pend_next   = 1'b0;
                        held_next   = 8'd0;
                        hvalid_next = 1'b0;
                        crc_next    = 8'd0;
                        tally_next  = 2'd0;
                    end
                    else if (char_data != CHAR_LF)
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (char_data == CHAR_LF)
                        phase_next = PH_START;
                end
                PH_CR:
                begin
                    if (char_data == CHAR_LF)
                        phase_next = PH_START;
                    else
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_FRAME;
                    end
                end
                PH_FRAME:
                begin
                    if (char_data == CHAR_CR)
                        phase_next = PH_CR;
                    else if (char_data == CHAR_LF)
                        phase_next = PH_START;
                    else if (!is_hex)
                        bad_next = 1'b1;
                    else if (!pend_reg)
                    begin
                        high_next = nib;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next   = 1'b0;
                        held_next   = new_byte;
                        hvalid_next = 1'b1;
                        crc_next    = crc8_byte(crc_reg, new_byte);
                        if (!tally_reg[1])
                            tally_next = tally_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (fire)
        begin
            case (phase_reg)
                PH_CR:
                begin
                    if (char_data == CHAR_LF)
                    begin
                        res_valid      = 1'b1;
                        res.frame_end  = 1'b1;
                        res.frame_good = !bad_reg && !pend_reg && (crc_reg == 8'd0)
                                         && tally_reg[1];
                    end
                end
                PH_FRAME:
                begin
                    if (char_data == CHAR_LF)
                    begin
                        res_valid     = 1'b1;
                        res.frame_end = 1'b1;
                    end
                    else if (char_data != CHAR_CR && is_hex && pend_reg && hvalid_reg)
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = held_reg;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            bad_reg    <= 1'b0;
            high_reg   <= 4'd0;
            pend_reg   <= 1'b0;
            held_reg   <= 8'd0;
            hvalid_reg <= 1'b0;
            crc_reg    <= 8'd0;
            tally_reg  <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bad_reg    <= bad_next;
            high_reg   <= high_next;
            pend_reg   <= pend_next;
            held_reg   <= held_next;
            hvalid_reg <= hvalid_next;
            crc_reg    <= crc_next;
            tally_reg  <= tally_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== hw/rtl/ahfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// ahfr_out_stage
// result register on the master side
// ----------------------------------------------------------------------------
module ahfr_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ahfr_pkg::res_t res,
    output logic           ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,    // [7:0] data_byte
    output logic           m_tlast,    // frame_end
    output logic           m_tuser     // frame_good
);
    import ahfr_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign ready = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data_byte;
    assign m_tlast  = res_reg.frame_end;
    assign m_tuser  = res_reg.frame_good;

endmodule

// ===== hw/rtl/ascii_hex_frame_receiver_crc8_core.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_crc8_core
// ':'-prefixed hex line receiver with crc-8 (poly 0x07) frame check
// ----------------------------------------------------------------------------
// accepted characters wait in the input register; results load the result register
// throughput: one character per cycle; the only stall is a full result register
// whose transaction is not taken (m_tready low), which holds the input register
// reset: rst_n clears both stage valids and returns the line phase to line start
`include "assert_macros.svh"

module ascii_hex_frame_receiver_crc8_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] data_byte
    output logic       m_tlast,     // frame_end
    output logic       m_tuser      // frame_good
);
    import ahfr_pkg::*;

    // input register -> frame core -> result register
    logic       char_valid;
    logic [7:0] char_data;
    logic       out_ready;
    logic       fire;
    logic       res_valid;
    res_t       res;
    phase_t     phase;

    // a held character is processed whenever the result register can take a result
    assign fire = char_valid && out_ready;

    ahfr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (out_ready),
        .char_valid (char_valid),
        .char_data  (char_data)
    );

    // phase, hex pairing, crc and the one-byte hold-back live here
    ahfr_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_data (char_data),
        .res_valid (res_valid),
        .res       (res),
        .phase     (phase)
    );

    // skid-free output register: loads only when a character yields a result
    ahfr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && res_valid),
        .res      (res),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // end-of-frame status always returns the receiver to line start
    `AHFR_ASSERT_NXT(a_end_to_start, clk, rst_n, fire && res_valid && res.frame_end, phase == PH_START)
    // back-pressure on the input only comes from a stalled full result register
    `AHFR_ASSERT_IMP(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // status transactions carry a zero byte, data transactions never claim good
    `AHFR_ASSERT_IMP(a_status_zero, clk, rst_n, m_tvalid && m_tlast, m_tdata == 8'd0)
    `AHFR_ASSERT_IMP(a_data_no_good, clk, rst_n, m_tvalid && !m_tlast, !m_tuser)

endmodule

// ===== verif/ascii_hex_frame_receiver_crc8_core_test.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_crc8_core_test
// self-checking bench for the ':' hex line receiver with crc-8 frame check
// ----------------------------------------------------------------------------
// a short directed character sequence (good frame, empty frame, empty line,
// skipped lines with extreme codes, non-hex digit, odd digit count, lf without
// cr, cr not followed by lf) is followed by random lines: mostly well-formed
// frames with random payload, a correct or corrupted crc byte and random digit
// case, mixed with injected faults, skipped lines, empty lines and raw noise.
// every accepted character runs through a local decoder that predicts the
// outgoing transactions; the monitor compares each one field by field.
// both sides insert random wait cycles, and some lines wait for a full drain.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver_crc8_core_test;

    import ahfr_pkg::*;

    localparam int RANDOM_CHARS = 1400;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [7:0] ch;
        bit         drain;      // hold this character until nothing is outstanding
    } pending_char_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    pending_char_t pending_chars[$];
    res_t          expected_results[$];

    int chars_total;
    int chars_accepted = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // driver and monitor pacing
    int            char_gap     = 0;
    int            char_calm    = 0;
    int            gap_draw;
    int            result_stall = 0;
    int            result_calm  = 0;
    int            stall_draw;
    pending_char_t head_char;
    res_t          want;

    // decoder state mirrored by the predictor
    phase_t     line_state        = PH_START;
    logic       seen_bad          = 1'b0;
    logic [3:0] upper_nibble      = 4'h0;
    logic       half_byte_pending = 1'b0;
    logic [7:0] delayed_byte      = 8'h00;
    logic       delayed_valid     = 1'b0;
    logic [7:0] running_crc       = 8'h00;
    logic [1:0] decoded_count     = 2'd0;

    ascii_hex_frame_receiver_crc8_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),        // [7:0] rx_char
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),        // [7:0] data_byte
        .m_tlast  (m_tlast),        // frame_end
        .m_tuser  (m_tuser)         // frame_good
    );

    always #5 clk = ~clk;

    // crc-8 poly 0x07, fed one message bit at a time, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[7] ^ b[k];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // {is_digit, value} of an ascii character
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
            return {1'b1, 4'(ch - "0")};
        if (ch >= "a" && ch <= "f")
            return {1'b1, 4'(ch - "a" + 8'd10)};
        if (ch >= "A" && ch <= "F")
            return {1'b1, 4'(ch - "A" + 8'd10)};
        return 5'h00;
    endfunction

    // ascii digit for a nibble, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return "0" + 8'(n);
        return (($urandom_range(0, 1) == 1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    // advance the mirrored decoder by one character, queue what it emits
    task automatic decode_char(input logic [7:0] ch);
        logic [4:0] digit;
        logic [7:0] full_byte;
        res_t       r;
        digit = hex_digit(ch);
        case (line_state)
            PH_START:
            begin
                if (ch == CHAR_COLON)
                begin
                    seen_bad          = 1'b0;
                    upper_nibble      = 4'h0;
                    half_byte_pending = 1'b0;
                    delayed_byte      = 8'h00;
                    delayed_valid     = 1'b0;
                    running_crc       = 8'h00;
                    decoded_count     = 2'd0;
                    line_state        = PH_FRAME;
                end
                else if (ch != CHAR_LF)
                    line_state = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (ch == CHAR_LF)
                    line_state = PH_START;
            end
            PH_CR:
            begin
                if (ch == CHAR_LF)
                begin
                    r.data_byte  = 8'h00;
                    r.frame_end  = 1'b1;
                    r.frame_good = !seen_bad && !half_byte_pending &&
                                   running_crc == 8'h00 && decoded_count == 2'd2;
                    expected_results.push_back(r);
                    line_state = PH_START;
                end
                else
                begin
                    // stray character after cr is dropped, frame goes bad
                    seen_bad   = 1'b1;
                    line_state = PH_FRAME;
                end
            end
            default:
            begin
                if (ch == CHAR_CR)
                    line_state = PH_CR;
                else if (ch == CHAR_LF)
                begin
                    // lf without cr always ends the frame as bad
                    r.data_byte  = 8'h00;
                    r.frame_end  = 1'b1;
                    r.frame_good = 1'b0;
                    expected_results.push_back(r);
                    line_state = PH_START;
                end
                else if (!digit[4])
                    seen_bad = 1'b1;
                else if (!half_byte_pending)
                begin
                    upper_nibble      = digit[3:0];
                    half_byte_pending = 1'b1;
                end
                else
                begin
                    half_byte_pending = 1'b0;
                    full_byte = {upper_nibble, digit[3:0]};
                    // previous byte leaves now, so the crc byte never does
                    if (delayed_valid)
                    begin
                        r.data_byte  = delayed_byte;
                        r.frame_end  = 1'b0;
                        r.frame_good = 1'b0;
                        expected_results.push_back(r);
                    end
                    delayed_byte  = full_byte;
                    delayed_valid = 1'b1;
                    running_crc   = crc8_next(running_crc, full_byte);
                    if (decoded_count != 2'd2)
                        decoded_count = decoded_count + 2'd1;
                end
            end
        endcase
    endtask

    task automatic queue_char(input logic [7:0] ch, input bit drain);
        pending_char_t p;
        p.ch    = ch;
        p.drain = drain;
        pending_chars.push_back(p);
    endtask

    task automatic queue_text(input string s);
        foreach (s[k])
            queue_char(s[k], 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // driver: presents one character per transaction, random gap after each
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            char_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata);
                chars_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (char_gap != 0)
                begin
                    char_gap <= char_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_chars.size() != 0 &&
                         (!pending_chars[0].drain || expected_results.size() == 0))
                begin
                    head_char = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= head_char.ch;
                    // occasional calm stretches with back-to-back characters
                    if (char_calm != 0)
                    begin
                        char_calm <= char_calm - 1;
                        gap_draw = 0;
                    end
                    else if ($urandom_range(0, 29) == 0)
                    begin
                        char_calm <= $urandom_range(20, 60);
                        gap_draw = 0;
                    end
                    else
                        gap_draw = $urandom_range(0, 12);
                    char_gap <= gap_draw;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, checks every result transaction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            result_stall <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %02h/%b/%b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.data_byte)
                begin
                    error_count++;
                    $display("%0t: data_byte mismatch, expected %02h, actual %02h",
                             $time, want.data_byte, m_tdata);
                end
                if (m_tlast !== want.frame_end)
                begin
                    error_count++;
                    $display("%0t: frame_end mismatch, expected %b, actual %b",
                             $time, want.frame_end, m_tlast);
                end
                if (m_tuser !== want.frame_good)
                begin
                    error_count++;
                    $display("%0t: frame_good mismatch, expected %b, actual %b",
                             $time, want.frame_good, m_tuser);
                end
            end
            if (result_calm != 0)
            begin
                result_calm <= result_calm - 1;
                stall_draw = 0;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                result_calm <= $urandom_range(20, 60);
                stall_draw = 0;
            end
            else
                stall_draw = $urandom_range(0, 12);
            result_stall <= stall_draw;
            m_tready     <= (stall_draw == 0);
        end
        else if (result_stall != 0)
        begin
            result_stall <= result_stall - 1;
            m_tready     <= (result_stall == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // cycles without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int         line_kind;
        int         payload_len;
        int         fault;
        int         pos;
        int         extra;
        bit         drain_line;
        bit         first_random;
        logic [7:0] payload_crc;
        logic [7:0] b;
        logic [7:0] line_buf[$];

        // directed: empty line
        queue_char(CHAR_LF, 1'b0);
        // good frame, payload 01, crc 07
        queue_text(":0107");
        queue_char(CHAR_CR, 1'b0);
        queue_char(CHAR_LF, 1'b0);
        // skipped lines starting with the extreme codes
        queue_char(8'hFF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(CHAR_LF, 1'b0);
        // empty frame, no bytes decoded
        queue_char(CHAR_COLON, 1'b0);
        queue_char(CHAR_CR, 1'b0);
        queue_char(CHAR_LF, 1'b0);
        // non-hex digit, odd count, lf without cr
        queue_text(":1G");
        queue_char(CHAR_LF, 1'b0);
        // cr followed by a digit, then lf alone
        queue_text(":12");
        queue_char(CHAR_CR, 1'b0);
        queue_text("3");
        queue_char(CHAR_LF, 1'b0);

        // random lines
        first_random = 1'b1;
        chars_total  = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < chars_total)
        begin
            line_kind  = $urandom_range(0, 19);
            drain_line = first_random || ($urandom_range(0, 24) == 0);
            first_random = 1'b0;
            line_buf.delete();
            if (line_kind < 14)
            begin
                // frame: payload, then its crc, sometimes corrupted
                line_buf.push_back(CHAR_COLON);
                payload_crc = 8'h00;
                payload_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                         : $urandom_range(0, 6);
                for (int k = 0; k <= payload_len; k++)
                begin
                    if (k < payload_len)
                    begin
                        b = 8'($urandom_range(0, 255));
                        payload_crc = crc8_next(payload_crc, b);
                    end
                    else
                    begin
                        b = payload_crc;
                        if ($urandom_range(0, 7) == 0)
                            b = b ^ 8'($urandom_range(1, 255));
                    end
                    line_buf.push_back(hex_char(b[7:4]));
                    line_buf.push_back(hex_char(b[3:0]));
                end
                fault = $urandom_range(0, 11);
                case (fault)
                    0:
                    begin
                        // stray character of any code
                        pos = $urandom_range(1, line_buf.size());
                        line_buf.insert(pos, 8'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        // lost digit
                        if (line_buf.size() > 1)
                            line_buf.delete($urandom_range(1, line_buf.size() - 1));
                    end
                    3:
                    begin
                        // cr in the middle followed by something other than lf
                        pos = $urandom_range(1, line_buf.size());
                        b = 8'($urandom_range(0, 255));
                        if (b == CHAR_LF)
                            b = CHAR_COLON;
                        line_buf.insert(pos, b);
                        line_buf.insert(pos, CHAR_CR);
                    end
                    default:
                    begin
                    end
                endcase
                if (fault != 2)
                    line_buf.push_back(CHAR_CR);
                line_buf.push_back(CHAR_LF);
            end
            else if (line_kind < 16)
            begin
                // line without the leading colon
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_COLON || b == CHAR_LF);
                line_buf.push_back(b);
                extra = $urandom_range(0, 10);
                for (int k = 0; k < extra; k++)
                begin
                    b = 8'($urandom_range(0, 255));
                    line_buf.push_back((b == CHAR_LF) ? CHAR_CR : b);
                end
                line_buf.push_back(CHAR_LF);
            end
            else if (line_kind == 16)
                line_buf.push_back(CHAR_LF);
            else
            begin
                // raw noise, may land in any line phase
                extra = $urandom_range(1, 6);
                for (int k = 0; k < extra; k++)
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            foreach (line_buf[k])
                queue_char(line_buf[k], drain_line && k == 0);
        end
        chars_total = pending_chars.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_accepted < chars_total || expected_results.size() != 0)
            @(posedge clk);
        // let any stray transaction surface
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
